>>> rtl/binomial_mod_prime_table_top_defines.svh
// ----------------------------------------------------------------------------
// Binomial table assertion macros
// Shared concurrent check macros for the binomial-mod-prime block.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_MOD_PRIME_TABLE_TOP_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define BMPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Check that a condition never holds outside reset
`define BMPT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define BMPT_ASSERT(lbl, prop)
`define BMPT_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> rtl/bmpt_pkg.sv
// ----------------------------------------------------------------------------
// Binomial table package
// Types and fixed constants shared by the binomial-mod-prime modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmpt_pkg;

  localparam int unsigned ModW = 30;
  localparam int unsigned ProdW = 2 * ModW;
  localparam int unsigned MmCntW = 6;
  localparam logic [MmCntW-1:0] MmSteps = MmCntW'(ProdW);
  localparam logic [ModW-1:0] ModReset = 30'd998244353;
  localparam logic [ModW-1:0] ModMin = 30'd2;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BF_MUL,
    S_BF_WAIT,
    S_PW_CHK,
    S_PW_ACC,
    S_PW_AWAIT,
    S_PW_SQ,
    S_PW_SWAIT,
    S_IV_CHK,
    S_IV_WAIT,
    S_Q_RD2,
    S_Q_M1,
    S_Q_W1,
    S_Q_M2,
    S_Q_W2,
    S_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

>>> rtl/binomial_mod_prime_table_top.sv
// ----------------------------------------------------------------------------
// Binomial coefficient modulo a prime
// Factorial and inverse-factorial tables in RAM, filled by a build item and
// read by query items that return n choose m.
// ----------------------------------------------------------------------------
// One item is processed at a time. Every modular product goes through one
// shared multiplier that reduces one product bit per cycle. A query makes
// three table reads and two products; a query that fails its checks makes
// neither. A build runs both table sweeps and the Fermat exponentiation.
// The tables read as garbage until the first build; a query before it
// reports "not built".
`timescale 1ns / 1ps

`include "binomial_mod_prime_table_top_defines.svh"

module binomial_mod_prime_table_top #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bmpt_pkg::ModW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [15:0]                top_count_i,
  input  logic signed [15:0]         choose_count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bmpt_pkg::ModW-1:0]  value_o,
  output logic [1:0]                 status_o
);
  import bmpt_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SIZE - 1);

  state_e          state_q, state_d;
  logic            ready_q, ready_d;
  logic [ModW-1:0] modulus_q;
  logic [ModW-1:0] p_q, p_d, p_eff;
  logic [ModW-1:0] acc_q, acc_d;
  logic [ModW-1:0] base_q, base_d;
  logic [ModW-1:0] exp_q, exp_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   nm_q, nm_d;
  logic [ModW-1:0] res_val_q, res_val_d;
  status_e         res_st_q, res_st_d;
  logic            out_valid_q, out_valid_d;
  logic [ModW-1:0] value_q, value_d;
  status_e         status_q, status_d;

  logic            in_xfer;
  logic            n_ok, m_ok;
  logic [15:0]     m_u, nm_full;

  logic            fact_we, fact_re, inv_we, inv_re;
  logic [AW-1:0]   fact_waddr, fact_raddr, inv_waddr, inv_raddr;
  logic [ModW-1:0] fact_wdata, inv_wdata, fact_rdata, inv_rdata;

  logic            mm_start;
  logic [ModW-1:0] mm_a, mm_b, mm_res;
  mm_stat_t        mm_stat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign p_eff      = (modulus_q < ModMin) ? ModMin : modulus_q;

  // decode the query operands
  assign m_u     = $unsigned(choose_count_i);
  assign nm_full = top_count_i - m_u;
  assign n_ok    = (32'(top_count_i) < 32'(TABLE_SIZE));
  assign m_ok    = !choose_count_i[15] && (m_u <= top_count_i);

  bmpt_ram #(.Depth(TABLE_SIZE), .Width(ModW)) u_fact_ram (
    .clk_i   (clk_i),
    .we_i    (fact_we),
    .waddr_i (fact_waddr),
    .wdata_i (fact_wdata),
    .re_i    (fact_re),
    .raddr_i (fact_raddr),
    .rdata_o (fact_rdata)
  );

  bmpt_ram #(.Depth(TABLE_SIZE), .Width(ModW)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (inv_waddr),
    .wdata_i (inv_wdata),
    .re_i    (inv_re),
    .raddr_i (inv_raddr),
    .rdata_o (inv_rdata)
  );

  bmpt_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .p_i     (p_q),
    .stat_o  (mm_stat),
    .res_o   (mm_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (cmd_i == CMD_BUILD) begin
            state_d = S_BF_MUL;
          end else if (ready_q && n_ok && m_ok) begin
            state_d = S_Q_RD2;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_BF_MUL:  state_d = S_BF_WAIT;
      S_BF_WAIT: begin
        if (mm_stat.done) begin
          state_d = (idx_q == LastIdx) ? S_PW_CHK : S_BF_MUL;
        end
      end
      S_PW_CHK: begin
        if (exp_q == '0) begin
          state_d = S_IV_CHK;
        end else if (exp_q[0]) begin
          state_d = S_PW_ACC;
        end else begin
          state_d = S_PW_SQ;
        end
      end
      S_PW_ACC:   state_d = S_PW_AWAIT;
      S_PW_AWAIT: if (mm_stat.done) state_d = S_PW_SQ;
      S_PW_SQ:    state_d = S_PW_SWAIT;
      S_PW_SWAIT: if (mm_stat.done) state_d = S_PW_CHK;
      S_IV_CHK:   state_d = (idx_q == AW'(1)) ? S_FIN : S_IV_WAIT;
      S_IV_WAIT:  if (mm_stat.done) state_d = S_IV_CHK;
      S_Q_RD2:    state_d = S_Q_M1;
      S_Q_M1:     state_d = S_Q_W1;
      S_Q_W1:     if (mm_stat.done) state_d = S_Q_M2;
      S_Q_M2:     state_d = S_Q_W2;
      S_Q_W2:     if (mm_stat.done) state_d = S_FIN;
      S_FIN:      if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath, memory and multiplier control
  always_comb begin
    ready_d     = ready_q;
    p_d         = p_q;
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    idx_d       = idx_q;
    nm_d        = nm_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    value_d     = value_q;
    status_d    = status_q;
    fact_we     = 1'b0;
    fact_waddr  = idx_q;
    fact_wdata  = mm_res;
    fact_re     = 1'b0;
    fact_raddr  = AW'(top_count_i);
    inv_we      = 1'b0;
    inv_waddr   = idx_q;
    inv_wdata   = mm_res;
    inv_re      = 1'b0;
    inv_raddr   = AW'(m_u);
    mm_start    = 1'b0;
    mm_a        = acc_q;
    mm_b        = base_q;
    // drop the result once it transfers
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          p_d = p_eff;
          if (cmd_i == CMD_BUILD) begin
            fact_we    = 1'b1;
            fact_waddr = '0;
            fact_wdata = ModW'(1);
            inv_we     = 1'b1;
            inv_waddr  = '0;
            inv_wdata  = ModW'(1);
            acc_d      = ModW'(1);
            idx_d      = AW'(1);
          end else begin
            res_val_d = '0;
            if (!ready_q) begin
              res_st_d = ST_NOT_BUILT;
            end else if (!n_ok) begin
              res_st_d = ST_RANGE;
            end else begin
              res_st_d = ST_OK;
            end
            if (ready_q && n_ok && m_ok) begin
              fact_re = 1'b1;
              inv_re  = 1'b1;
              nm_d    = AW'(nm_full);
            end
          end
        end
      end
      S_BF_MUL: begin
        mm_start = 1'b1;
        mm_a     = acc_q;
        mm_b     = ModW'(idx_q);
      end
      S_BF_WAIT: begin
        if (mm_stat.done) begin
          fact_we = 1'b1;
          if (idx_q == LastIdx) begin
            base_d = mm_res;
            acc_d  = ModW'(1);
            exp_d  = p_q - ModMin;
          end else begin
            acc_d = mm_res;
            idx_d = idx_q + AW'(1);
          end
        end
      end
      S_PW_CHK: begin
        if (exp_q == '0) begin
          inv_we    = 1'b1;
          inv_waddr = LastIdx;
          inv_wdata = acc_q;
          idx_d     = LastIdx;
        end
      end
      S_PW_ACC: begin
        mm_start = 1'b1;
        mm_a     = acc_q;
        mm_b     = base_q;
      end
      S_PW_AWAIT: if (mm_stat.done) acc_d = mm_res;
      S_PW_SQ: begin
        mm_start = 1'b1;
        mm_a     = base_q;
        mm_b     = base_q;
      end
      S_PW_SWAIT: begin
        if (mm_stat.done) begin
          base_d = mm_res;
          exp_d  = exp_q >> 1;
        end
      end
      S_IV_CHK: begin
        if (idx_q == AW'(1)) begin
          ready_d   = 1'b1;
          res_val_d = '0;
          res_st_d  = ST_OK;
        end else begin
          mm_start = 1'b1;
          mm_a     = acc_q;
          mm_b     = ModW'(idx_q);
        end
      end
      S_IV_WAIT: begin
        if (mm_stat.done) begin
          acc_d     = mm_res;
          inv_we    = 1'b1;
          inv_waddr = idx_q - AW'(1);
          idx_d     = idx_q - AW'(1);
        end
      end
      S_Q_RD2: begin
        // keep inv[m], fetch inv[n-m]
        acc_d     = inv_rdata;
        inv_re    = 1'b1;
        inv_raddr = nm_q;
      end
      S_Q_M1: begin
        mm_start = 1'b1;
        mm_a     = inv_rdata;
        mm_b     = acc_q;
      end
      S_Q_W1: if (mm_stat.done) acc_d = mm_res;
      S_Q_M2: begin
        mm_start = 1'b1;
        mm_a     = fact_rdata;
        mm_b     = acc_q;
      end
      S_Q_W2: begin
        if (mm_stat.done) begin
          res_val_d = mm_res;
          res_st_d  = ST_OK;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          value_d     = res_val_q;
          status_d    = res_st_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      modulus_q   <= ModReset;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    acc_q     <= acc_d;
    base_q    <= base_d;
    exp_q     <= exp_d;
    idx_q     <= idx_d;
    nm_q      <= nm_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    value_q   <= value_d;
    status_q  <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  `BMPT_ASSERT_NEVER(a_ready_falls, $fell(ready_q))
  `BMPT_ASSERT(a_err_zero, out_valid_q |-> (status_q == ST_OK || value_q == '0))

endmodule

>>> rtl/bmpt_ram.sv
// ----------------------------------------------------------------------------
// Table RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpt_ram #(
  parameter int Depth = 1024,
  parameter int Width = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bmpt_modmul.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Registered 30x30 product, then remainder by restoring reduction, one bit
// of the product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "binomial_mod_prime_table_top_defines.svh"

module bmpt_modmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bmpt_pkg::ModW-1:0]  a_i,
  input  logic [bmpt_pkg::ModW-1:0]  b_i,
  input  logic [bmpt_pkg::ModW-1:0]  p_i,
  output bmpt_pkg::mm_stat_t         stat_o,
  output logic [bmpt_pkg::ModW-1:0]  res_o
);
  import bmpt_pkg::*;

  logic [ProdW-1:0]  prod_q, prod_d;
  logic [ModW-1:0]   rem_q, rem_d;
  logic [MmCntW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ModW:0]     trial;

  // shift one product bit into the remainder, subtract once if needed
  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, prod_q[ProdW-1]};
    if (start_i) begin
      prod_d = ProdW'(a_i) * ProdW'(b_i);
      rem_d  = '0;
      cnt_d  = MmSteps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, p_i}) begin
        rem_d = ModW'(trial - {1'b0, p_i});
      end else begin
        rem_d = trial[ModW-1:0];
      end
      prod_d = {prod_q[ProdW-2:0], 1'b0};
      cnt_d  = cnt_q - MmCntW'(1);
      if (cnt_q == MmCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // hold datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = rem_q;

  `BMPT_ASSERT_NEVER(a_start_busy, start_i && busy_q)
  `BMPT_ASSERT(a_done_pulse, done_q |=> !done_q)
  `BMPT_ASSERT(a_rem_reduced, busy_q |-> (rem_q < p_i))

endmodule

>>> tb/binomial_mod_prime_table_top_tb.sv
// ----------------------------------------------------------------------------
// Binomial table block testbench
// Drives build and query transfers into the binomial-mod-prime block and
// checks every result against directed rows or in-bench factorial tables.
// Includes a directed table, then random phases with different moduli and
// different sender/receiver idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binomial_mod_prime_table_top_tb;
  import bmpt_pkg::*;

  localparam int          TblSize    = 1024;
  localparam int          NumPhases  = 5;
  localparam int          PhaseItems = 250;
  localparam int          StaleItems = 20;
  localparam longint      CycleLimit = 4000000;

  // Idle patterns, one per phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  typedef struct {
    logic [ModW-1:0] value;
    status_e         status;
  } binom_res_t;

  typedef struct {
    cmd_e            cmd;
    logic [15:0]     n;
    logic [15:0]     m;
    bit              typed;
    logic [ModW-1:0] value;
    status_e         status;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [ModW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_stall_o;
  logic            cmd_i;
  logic [15:0]     top_count_i;
  logic [15:0]     choose_count_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [ModW-1:0] value_o;
  logic [1:0]      status_o;

  // Model state
  longint unsigned fact_tbl[TblSize];
  longint unsigned inv_fact_tbl[TblSize];
  bit              tables_built;
  logic [ModW-1:0] cur_modulus;

  binom_res_t      pending_q[$];
  idle_e           idle_mode;
  int              err_count;
  int              checked_count;
  longint          cycle_count;

  binomial_mod_prime_table_top #(
    .TABLE_SIZE(TblSize)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .top_count_i    (top_count_i),
    .choose_count_i (choose_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .status_o       (status_o)
  );

  // Generate clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned eff_modulus();
    return (cur_modulus < 2) ? 64'd2 : 64'(cur_modulus);
  endfunction

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                             longint unsigned p);
    return ((a % p) * (b % p)) % p;
  endfunction

  function automatic longint unsigned powmod(longint unsigned base, longint unsigned ex,
                                             longint unsigned p);
    longint unsigned acc;
    acc = 1 % p;
    base = base % p;
    while (ex != 0) begin
      if (ex[0]) acc = mulmod(acc, base, p);
      base = mulmod(base, base, p);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // Fill both factorial tables as the block does on a build
  function automatic void build_tables();
    longint unsigned p;
    p = eff_modulus();
    fact_tbl[0] = 1 % p;
    for (int i = 1; i < TblSize; i++) fact_tbl[i] = mulmod(fact_tbl[i-1], i, p);
    inv_fact_tbl[0] = 1 % p;
    inv_fact_tbl[TblSize-1] = powmod(fact_tbl[TblSize-1], p - 2, p);
    for (int i = TblSize - 2; i >= 1; i--)
      inv_fact_tbl[i] = mulmod(inv_fact_tbl[i+1], i + 1, p);
    tables_built = 1'b1;
  endfunction

  // Work out the result of one item and advance the model
  function automatic binom_res_t choose_mod(cmd_e cmd, logic [15:0] n, logic [15:0] m);
    binom_res_t      r;
    longint unsigned p;
    r.value  = '0;
    r.status = ST_OK;
    if (cmd == CMD_BUILD) begin
      build_tables();
    end else if (!tables_built) begin
      r.status = ST_NOT_BUILT;
    end else if (n >= TblSize) begin
      r.status = ST_RANGE;
    end else if (!m[15] && m <= n) begin
      p = eff_modulus();
      r.value = ModW'(mulmod(fact_tbl[n], mulmod(inv_fact_tbl[n-m], inv_fact_tbl[m], p), p));
    end
    return r;
  endfunction

  // Drive the receiver stall according to the idle pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall_i <= ($urandom_range(99) < 87);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall_i <= ($urandom_range(99) < 27);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    binom_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time, value_o, status_o);
        err_count++;
      end else begin
        want = pending_q.pop_front();
        checked_count++;
        if (value_o !== want.value) begin
          $display("%0t: value mismatch expected=%0d actual=%0d", $time, want.value, value_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
                   status_o);
          err_count++;
        end
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Present one item and hold it until its transfer
  task automatic send_item(cmd_e cmd, logic [15:0] n, logic [15:0] m, bit typed,
                           binom_res_t typed_res);
    binom_res_t r;
    int         idle_pct;
    idle_pct = (idle_mode == IDLE_SEND) ? 87 : (idle_mode == IDLE_BOTH) ? 27 : 0;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    top_count_i    <= n;
    choose_count_i <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = choose_mod(cmd, n, m);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  // Hold off the sender until every result is back and the block is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [ModW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_modulus = v;
  endtask

  task automatic send_random_query();
    logic [15:0] n;
    logic [15:0] m;
    int          pick;
    binom_res_t  none;
    none = '{value: '0, status: ST_OK};
    pick = $urandom_range(99);
    if (pick < 80) begin
      n = 16'($urandom_range(TblSize - 1));
      m = 16'($urandom_range(n));
    end else if (pick < 88) begin
      n = 16'($urandom_range(TblSize - 1));
      m = 16'($urandom);
    end else if (pick < 95) begin
      n = 16'($urandom);
      m = 16'($urandom);
    end else begin
      n = 16'($urandom_range(TblSize - 1));
      m = 16'(n + $urandom_range(1, 50));
    end
    send_item(CMD_QUERY, n, m, 1'b0, none);
  endtask

  dir_row_t        dir_tbl[16];
  logic [ModW-1:0] phase_mod[NumPhases];
  binom_res_t      row_res;

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_QUERY;
    top_count_i    = '0;
    choose_count_i = '0;
    idle_mode      = IDLE_NONE;
    err_count      = 0;
    checked_count  = 0;
    cycle_count    = 0;
    tables_built   = 1'b0;
    cur_modulus    = ModReset;

    dir_tbl = '{
      '{CMD_QUERY, 16'd5,     16'd2,      1'b1, 30'd0,    ST_NOT_BUILT},
      '{CMD_BUILD, 16'd0,     16'd0,      1'b1, 30'd0,    ST_OK},
      '{CMD_QUERY, 16'd1024,  16'd0,      1'b1, 30'd0,    ST_RANGE},
      '{CMD_QUERY, 16'hFFFF,  16'h7FFF,   1'b1, 30'd0,    ST_RANGE},
      '{CMD_QUERY, 16'h8000,  16'd5,      1'b1, 30'd0,    ST_RANGE},
      '{CMD_QUERY, 16'd10,    16'hFFFF,   1'b1, 30'd0,    ST_OK},
      '{CMD_QUERY, 16'd10,    16'h8000,   1'b1, 30'd0,    ST_OK},
      '{CMD_QUERY, 16'd3,     16'd4,      1'b1, 30'd0,    ST_OK},
      '{CMD_QUERY, 16'd0,     16'd1,      1'b1, 30'd0,    ST_OK},
      '{CMD_QUERY, 16'd0,     16'd0,      1'b1, 30'd1,    ST_OK},
      '{CMD_QUERY, 16'd1023,  16'd0,      1'b1, 30'd1,    ST_OK},
      '{CMD_QUERY, 16'd1023,  16'd1023,   1'b1, 30'd1,    ST_OK},
      '{CMD_QUERY, 16'd1023,  16'd1,      1'b1, 30'd1023, ST_OK},
      '{CMD_QUERY, 16'd5,     16'd2,      1'b1, 30'd10,   ST_OK},
      '{CMD_QUERY, 16'd1023,  16'd511,    1'b0, 30'd0,    ST_OK},
      '{CMD_QUERY, 16'd1000,  16'd300,    1'b0, 30'd0,    ST_OK}
    };
    phase_mod = '{30'd2, 30'h3FFFFFFF, 30'd1000003, 30'd0, 30'd1073741789};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset modulus
    foreach (dir_tbl[i]) begin
      row_res = '{value: dir_tbl[i].value, status: dir_tbl[i].status};
      send_item(dir_tbl[i].cmd, dir_tbl[i].n, dir_tbl[i].m, dir_tbl[i].typed, row_res);
    end
    drain();

    // Random phases: new modulus, queries on stale tables, rebuild, queries
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_mode = (ph == 1) ? IDLE_SEND : (ph == 2) ? IDLE_RECV :
                  (ph == 3) ? IDLE_BOTH : IDLE_NONE;
      write_modulus(phase_mod[ph]);
      for (int k = 0; k < StaleItems; k++) send_random_query();
      row_res = '{value: '0, status: ST_OK};
      send_item(CMD_BUILD, 16'($urandom), 16'($urandom), 1'b0, row_res);
      for (int k = 0; k < PhaseItems - StaleItems - 1; k++) begin
        send_random_query();
        if (k == 100) drain();
      end
      drain();
    end

    // Final wait for stragglers
    repeat (200) @(posedge clk_i);
    $display("Covered directed edge cases and %0d moduli phases with mixed idle patterns;",
             NumPhases);
    $display("%0d results checked, %0d errors.", checked_count, err_count);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bmpt_pkg.sv
rtl/bmpt_ram.sv
rtl/bmpt_modmul.sv
rtl/binomial_mod_prime_table_top.sv
tb/binomial_mod_prime_table_top_tb.sv
